// File: rtl/core/rtfb_pkg.sv
// ----------------------------------------------------------------------------
// rtfb_pkg
// Types and constants shared by the transmit-request frame builder.
// ----------------------------------------------------------------------------
package rtfb_pkg;

  localparam int MAX_PAYLOAD  = 256;
  localparam int COUNT_W      = 9;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int HDR_IDX_W    = 5;

  localparam logic [7:0]  START_MARK  = 8'h7E;
  localparam logic [15:0] LENGTH_BASE = 16'd14;
  localparam logic [7:0]  SUM_INVERT  = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_LONG  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_SHORT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_KIND = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TAG  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TX_OPTIONS = 3'd5;

  // Header byte positions, in transmit order.
  localparam logic [HDR_IDX_W-1:0] HDR_START     = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI    = 5'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO    = 5'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_KIND      = 5'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_TAG       = 5'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_LONG_MSB  = 5'd5;
  localparam logic [HDR_IDX_W-1:0] HDR_LONG_LSB  = 5'd12;
  localparam logic [HDR_IDX_W-1:0] HDR_SHORT_HI  = 5'd13;
  localparam logic [HDR_IDX_W-1:0] HDR_SHORT_LO  = 5'd14;
  localparam logic [HDR_IDX_W-1:0] HDR_HOP       = 5'd15;
  localparam logic [HDR_IDX_W-1:0] HDR_OPTIONS   = 5'd16;

  typedef struct packed {
    logic [63:0] dest_long_address;
    logic [15:0] dest_short_address;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_tag;
    logic [7:0]  hop_limit;
    logic [7:0]  transmit_options;
  } cfg_t;

  // One classified payload byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
    logic               first;
    logic               last;
  } entry_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_HDR,
    ST_PAY,
    ST_CSUM
  } back_state_t;

endpackage

// File: rtl/core/rtfb_if.sv
// ----------------------------------------------------------------------------
// rtfb_if
// Valid/ready channels for payload bytes in and frame bytes out.
// ----------------------------------------------------------------------------
interface rtfb_payload_if
  import rtfb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [7:0]         payload_byte;
  logic [COUNT_W-1:0] payload_count;

  modport source (output valid, output payload_byte, output payload_count, input ready);
  modport sink   (input valid, input payload_byte, input payload_count, output ready);
endinterface

interface rtfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// File: rtl/core/radio_api_tx_frame_builder.sv
// ----------------------------------------------------------------------------
// radio_api_tx_frame_builder
// Builds API transmit-request frames (header, payload, checksum) from a
// stream of payload bytes, with addressing fields held in registers.
//
//   channel   dir   transaction          fields
//   payload   in    one payload byte     payload_byte[7:0], payload_count[8:0]
//   frame     out   one frame byte       out_byte[7:0], frame_end
//   cfg       in    one register write   cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// The output register sends one byte per cycle while the frame side is ready:
// a frame's first payload byte follows the 17 header bytes, and its last byte
// is followed by the checksum.
// A four-entry queue lets payload bytes keep arriving while the header goes out.
// Reset is synchronous and loads the register defaults; no clearing pass.
// Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module radio_api_tx_frame_builder
  import rtfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rtfb_payload_if.sink           payload,
  rtfb_frame_if.source           frame
);

  cfg_t   cfg;
  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_long_address  <= '0;
      cfg.dest_short_address <= 16'hFFFE;
      cfg.frame_kind         <= 8'h10;
      cfg.frame_tag          <= 8'h01;
      cfg.hop_limit          <= '0;
      cfg.transmit_options   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST_LONG:  cfg.dest_long_address  <= cfg_data;
        REG_DEST_SHORT: cfg.dest_short_address <= cfg_data[15:0];
        REG_FRAME_KIND: cfg.frame_kind         <= cfg_data[7:0];
        REG_FRAME_TAG:  cfg.frame_tag          <= cfg_data[7:0];
        REG_HOP_LIMIT:  cfg.hop_limit          <= cfg_data[7:0];
        REG_TX_OPTIONS: cfg.transmit_options   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rtfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .payload    (payload),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rtfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  rtfb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .frame   (frame)
  );

endmodule

// File: rtl/core/rtfb_front.sv
// ----------------------------------------------------------------------------
// rtfb_front
// Accepts payload bytes and tags each as first and/or last of its frame.
// ----------------------------------------------------------------------------
module rtfb_front
  import rtfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  rtfb_payload_if.sink        payload,
  input  logic                q_full,
  output logic                push,
  output entry_t              push_entry
);

  logic [COUNT_W-1:0] bytes_remaining;
  logic [COUNT_W-1:0] bytes_remaining_next;
  logic [COUNT_W-1:0] count_sat;
  logic               first;

  assign payload.ready = !q_full;
  assign push          = payload.valid && payload.ready;
  assign first         = (bytes_remaining == '0);

  always_comb begin
    // A zero count still covers the byte that carries it.
    if (payload.payload_count == '0) begin
      count_sat = COUNT_W'(1);
    end else if (payload.payload_count > COUNT_W'(MAX_PAYLOAD)) begin
      count_sat = COUNT_W'(MAX_PAYLOAD);
    end else begin
      count_sat = payload.payload_count;
    end

    if (first) begin
      bytes_remaining_next = count_sat - COUNT_W'(1);
    end else begin
      bytes_remaining_next = bytes_remaining - COUNT_W'(1);
    end

    push_entry.data  = payload.payload_byte;
    push_entry.count = count_sat;
    push_entry.first = first;
    push_entry.last  = (bytes_remaining_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
    end else if (push) begin
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// File: rtl/core/rtfb_queue.sv
// ----------------------------------------------------------------------------
// rtfb_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module rtfb_queue
  import rtfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/rtfb_back.sv
// ----------------------------------------------------------------------------
// rtfb_back
// Serializes queued entries into header, payload and checksum bytes.
// ----------------------------------------------------------------------------
module rtfb_back
  import rtfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_empty,
  input  entry_t        head,
  output logic          pop,
  rtfb_frame_if.source  frame
);

  back_state_t          state;
  back_state_t          state_next;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [HDR_IDX_W-1:0] hdr_idx_next;
  logic [7:0]           running_sum;
  logic [7:0]           running_sum_next;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 out_end;
  logic                 advance;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 emit_end;
  logic [7:0]           hdr_byte;
  logic [15:0]          frame_len;
  logic [2:0]           long_sel;

  assign frame.valid     = out_valid;
  assign frame.out_byte  = out_byte;
  assign frame.frame_end = out_end;
  assign advance         = !out_valid || frame.ready;

  assign frame_len = 16'(head.count) + LENGTH_BASE;
  // Byte 5 of the header is the most significant byte of the long address.
  assign long_sel  = 3'(HDR_LONG_LSB - hdr_idx);

  always_comb begin
    case (hdr_idx)
      HDR_START:    hdr_byte = START_MARK;
      HDR_LEN_HI:   hdr_byte = frame_len[15:8];
      HDR_LEN_LO:   hdr_byte = frame_len[7:0];
      HDR_KIND:     hdr_byte = cfg.frame_kind;
      HDR_TAG:      hdr_byte = cfg.frame_tag;
      HDR_SHORT_HI: hdr_byte = cfg.dest_short_address[15:8];
      HDR_SHORT_LO: hdr_byte = cfg.dest_short_address[7:0];
      HDR_HOP:      hdr_byte = cfg.hop_limit;
      HDR_OPTIONS:  hdr_byte = cfg.transmit_options;
      default: begin
        if (hdr_idx inside {[HDR_LONG_MSB:HDR_LONG_LSB]}) begin
          hdr_byte = cfg.dest_long_address[{long_sel, 3'b000} +: 8];
        end else begin
          hdr_byte = '0;
        end
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    hdr_idx_next     = hdr_idx;
    running_sum_next = running_sum;
    emit             = 1'b0;
    emit_byte        = '0;
    emit_end         = 1'b0;
    pop              = 1'b0;

    if (advance) begin
      case (state)
        ST_DATA: begin
          if (!q_empty) begin
            emit = 1'b1;
            if (head.first) begin
              emit_byte        = START_MARK;
              running_sum_next = '0;
              hdr_idx_next     = HDR_LEN_HI;
              state_next       = ST_HDR;
            end else begin
              emit_byte        = head.data;
              running_sum_next = running_sum + head.data;
              pop              = 1'b1;
              state_next       = head.last ? ST_CSUM : ST_DATA;
            end
          end
        end
        ST_HDR: begin
          emit      = 1'b1;
          emit_byte = hdr_byte;
          // The start mark and the length stay out of the checksum.
          if (hdr_idx >= HDR_KIND) begin
            running_sum_next = running_sum + hdr_byte;
          end
          hdr_idx_next = hdr_idx + HDR_IDX_W'(1);
          if (hdr_idx == HDR_OPTIONS) begin
            state_next = ST_PAY;
          end
        end
        ST_PAY: begin
          emit             = 1'b1;
          emit_byte        = head.data;
          running_sum_next = running_sum + head.data;
          pop              = 1'b1;
          state_next       = head.last ? ST_CSUM : ST_DATA;
        end
        ST_CSUM: begin
          emit       = 1'b1;
          emit_byte  = SUM_INVERT - running_sum;
          emit_end   = 1'b1;
          state_next = ST_DATA;
        end
        default: begin
          state_next = ST_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_DATA;
      hdr_idx     <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      hdr_idx     <= hdr_idx_next;
      running_sum <= running_sum_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_byte <= emit_byte;
      out_end  <= emit_end;
    end
  end

endmodule
